>>> rtl/kvls_pkg.sv
// Package for the key/value line splitter.
// Holds byte constants, field widths and the result record shared by the top level and the tracker.
// No dependencies.
`default_nettype none

package kvls_pkg;

    localparam int FIELD_BITS = 16;

    localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;
    localparam logic [7:0] SPACE_BYTE      = 8'h20;
    localparam logic [7:0] DELIMITER_RESET = 8'h3A;

    // One line summary, as it leaves the block
    typedef struct packed {
        logic                  found;
        logic [FIELD_BITS-1:0] key_offset;
        logic [FIELD_BITS-1:0] key_length;
        logic [FIELD_BITS-1:0] value_offset;
        logic [FIELD_BITS-1:0] value_length;
        logic                  end_of_buffer;
        logic                  overflow;
    } kvls_result_t;

endpackage

`default_nettype wire

>>> rtl/key_value_line_splitter.sv
// Top level of the key/value line splitter: input stage, line tracker, result register.
// Depends on kvls_pkg, kvls_in_stage and kvls_tracker.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] text_byte, tlast last_byte
//   m_axis    out        tdata key_offset/key_length/value_offset/value_length,
//                        tuser found/overflow, tlast end_of_buffer
//   cfg       in         cfg_wdata delimiter, written when cfg_we is high
//
// One byte per cycle while no stalled result holds the flow; a byte is registered in the input
// register, and its line summary is registered in the result register when that byte advances
// out of the input register.
// rst_n is asynchronous and clears the valid flags of both stages, position, line state and overflow;
// the delimiter returns to ':'.
// A stalled result holds a byte that closes a line in the input register; bytes
// that close no line keep flowing until such a byte reaches it.
`default_nettype none

module key_value_line_splitter
#(
    parameter int OFFSET_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,      // delimiter
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // key_offset, key_length, value_offset, value_length
    output logic [1:0]       m_axis_tuser,   // found, overflow
    output logic             m_axis_tlast    // end_of_buffer
);
    import kvls_pkg::*;

    logic [7:0]   delim_reg;
    logic         held_valid;
    logic [7:0]   held_byte;
    logic         held_last;
    logic         advance;
    logic         line_done;
    kvls_result_t line_result;
    kvls_result_t out_reg;
    logic         out_valid_reg;
    logic         out_valid_next;

    // Delimiter register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIMITER_RESET;
        end
        else if (cfg_we)
        begin
            delim_reg <= cfg_wdata;
        end
    end

    kvls_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .consume    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    kvls_tracker #(.OFFSET_BITS(OFFSET_BITS)) u_tracker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .text_byte (held_byte),
        .last_byte (held_last),
        .delimiter (delim_reg),
        .line_done (line_done),
        .result    (line_result)
    );

    // Advance when the byte makes no result or the result slot is free
    assign advance = held_valid && (!line_done || !out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && line_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: load when a line closes
    always_ff @(posedge clk)
    begin
        if (advance && line_done)
        begin
            out_reg <= line_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.value_length, out_reg.value_offset,
                            out_reg.key_length, out_reg.key_offset};
    assign m_axis_tuser  = {out_reg.overflow, out_reg.found};
    assign m_axis_tlast  = out_reg.end_of_buffer;

`ifndef SYNTHESIS
    // A line without a pair carries no offsets or lengths
    a_no_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 64'd0))
        else $error("result without a pair has nonzero fields");

    // A closing byte never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && line_done) |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten while stalled");

    // Input back-pressure only when a byte is held
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid |-> s_axis_tready)
        else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire

>>> rtl/kvls_in_stage.sv
// Input register of the key/value line splitter.
// Holds one byte transaction until the tracker consumes it. Uses no package items.
`default_nettype none

module kvls_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       consume,
    output logic            held_valid,
    output logic [7:0]      held_byte,
    output logic            held_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Take a new byte whenever the slot is empty or drains this cycle
    assign in_ready = !valid_reg || consume;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load on acceptance
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

`default_nettype wire

>>> rtl/kvls_tracker.sv
// Line tracker of the key/value line splitter: position, delimiter and trim bounds.
// Builds the line summary for the byte at its input. Depends on kvls_pkg.
`default_nettype none

module kvls_tracker
#(
    parameter int OFFSET_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            text_byte,
    input  wire logic                  last_byte,
    input  wire logic [7:0]            delimiter,
    output logic                       line_done,
    output kvls_pkg::kvls_result_t     result
);
    import kvls_pkg::*;

    // Offsets live in at most FIELD_BITS bits; the limit is all ones there
    localparam int PW = (OFFSET_BITS >= FIELD_BITS) ? FIELD_BITS : OFFSET_BITS;
    localparam logic [PW-1:0] LIMIT = {PW{1'b1}};

    logic [PW-1:0] position_reg,    position_next;
    logic          seen_reg,        seen_next;
    logic [PW-1:0] delim_at_reg,    delim_at_next;
    logic [PW-1:0] key_begin_reg,   key_begin_next;
    logic          key_valid_reg,   key_valid_next;
    logic [PW-1:0] key_end_reg,     key_end_next;
    logic [PW-1:0] value_begin_reg, value_begin_next;
    logic          value_valid_reg, value_valid_next;
    logic [PW-1:0] value_end_reg,   value_end_next;
    logic          overflow_reg,    overflow_next;

    logic          is_newline;
    logic          is_space;
    logic          at_limit;
    logic [PW-1:0] after;
    logic [PW-1:0] close_pos;

    assign is_newline = (text_byte == NEWLINE_BYTE);
    assign is_space   = (text_byte == SPACE_BYTE);
    assign at_limit   = (position_reg == LIMIT);
    assign after      = at_limit ? position_reg : position_reg + 1'b1;
    assign line_done  = is_newline || last_byte;
    assign close_pos  = is_newline ? position_reg : after;

    // Update bounds for the current byte
    always_comb
    begin
        seen_next        = seen_reg;
        delim_at_next    = delim_at_reg;
        key_begin_next   = key_begin_reg;
        key_valid_next   = key_valid_reg;
        key_end_next     = key_end_reg;
        value_begin_next = value_begin_reg;
        value_valid_next = value_valid_reg;
        value_end_next   = value_end_reg;
        overflow_next    = overflow_reg || at_limit;
        position_next    = after;
        if (!is_newline)
        begin
            if (!seen_reg && text_byte == delimiter)
            begin
                seen_next     = 1'b1;
                delim_at_next = position_reg;
            end
            else if (!seen_reg)
            begin
                if (!is_space)
                begin
                    if (!key_valid_reg)
                    begin
                        key_begin_next = position_reg;
                        key_valid_next = 1'b1;
                    end
                    key_end_next = after;
                end
            end
            else if (!is_space)
            begin
                if (!value_valid_reg)
                begin
                    value_begin_next = position_reg;
                    value_valid_next = 1'b1;
                end
                value_end_next = after;
            end
        end
    end

    // Build the summary from the updated bounds
    always_comb
    begin
        result               = '0;
        result.end_of_buffer = last_byte;
        result.overflow      = overflow_next;
        if (seen_next)
        begin
            result.found = 1'b1;
            if (key_valid_next)
            begin
                result.key_offset = FIELD_BITS'(key_begin_next);
                result.key_length = FIELD_BITS'(key_end_next - key_begin_next);
            end
            else
            begin
                result.key_offset = FIELD_BITS'(delim_at_next);
            end
            if (value_valid_next)
            begin
                result.value_offset = FIELD_BITS'(value_begin_next);
                result.value_length = FIELD_BITS'(value_end_next - value_begin_next);
            end
            else
            begin
                result.value_offset = FIELD_BITS'(close_pos);
            end
        end
    end

    // Advance state; clear the line at its end and everything at buffer end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            seen_reg        <= 1'b0;
            delim_at_reg    <= '0;
            key_begin_reg   <= '0;
            key_valid_reg   <= 1'b0;
            key_end_reg     <= '0;
            value_begin_reg <= '0;
            value_valid_reg <= 1'b0;
            value_end_reg   <= '0;
            overflow_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (line_done)
            begin
                seen_reg        <= 1'b0;
                delim_at_reg    <= '0;
                key_begin_reg   <= '0;
                key_valid_reg   <= 1'b0;
                key_end_reg     <= '0;
                value_begin_reg <= '0;
                value_valid_reg <= 1'b0;
                value_end_reg   <= '0;
            end
            else
            begin
                seen_reg        <= seen_next;
                delim_at_reg    <= delim_at_next;
                key_begin_reg   <= key_begin_next;
                key_valid_reg   <= key_valid_next;
                key_end_reg     <= key_end_next;
                value_begin_reg <= value_begin_next;
                value_valid_reg <= value_valid_next;
                value_end_reg   <= value_end_next;
            end
            if (last_byte)
            begin
                position_reg <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                position_reg <= position_next;
                overflow_reg <= overflow_next;
            end
        end
    end

endmodule

`default_nettype wire
